/* rtl/dspc_pkg.sv */
// Shared constants and opcodes for the countdown delay slot pool.
package dspc_pkg;

    // Field widths
    localparam int OPCODE_W   = 2;
    localparam int COUNT_W    = 32;
    localparam int SLOT_IDX_W = 3;

    // Stream bus widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;

    // Pool size default
    localparam int DEFAULT_NUM_SLOTS = 8;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_QUERY   = 2'd3;

    // Status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_SLOT = 1'b1;

endpackage

/* rtl/dspc_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module dspc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on strobe, register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/delay_slot_pool_countdown_top.sv */
// Top level of the countdown delay slot pool: sequencer, slot flags and counter RAM.
// From accept to m_tvalid: a tick walks every slot in ST_TICK, an allocate scans ST_ALLOC up to the
// lowest free slot (every slot when the pool is full), release and query go straight to ST_RESP.
// One item at a time: s_tready rises again the cycle after the result is loaded, so a tick
// holds off the next beat for the whole walk over the counter RAM through one decrementer.
// aresetn (synchronous, active low) frees every slot and clears every done flag; counters
// need no clearing because allocate loads a slot's counter before any tick reads it.
module delay_slot_pool_countdown_top #(
    parameter int NUM_SLOTS = dspc_pkg::DEFAULT_NUM_SLOTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Input beat
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dspc_pkg::S_TDATA_W-1:0] s_tdata,   // delay_count[31:0], slot_index[34:32]
    input  logic [dspc_pkg::S_TUSER_W-1:0] s_tuser,   // opcode[1:0]
    // Result beat
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dspc_pkg::M_TDATA_W-1:0] m_tdata    // status[0], granted_slot[3:1],
                                                      // slot_done[4]
);

    import dspc_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CMP_W  = (SLOT_W + 1 > SLOT_IDX_W) ? SLOT_W + 1 : SLOT_IDX_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_ALLOC,
        ST_RESP
    } state_t;

    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [NUM_SLOTS-1:0]   free_reg, free_next;
    logic [NUM_SLOTS-1:0]   done_reg, done_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [SLOT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                   res_status_reg, res_status_next;
    logic [SLOT_IDX_W-1:0]  res_slot_reg, res_slot_next;
    logic                   res_done_reg, res_done_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    logic [OPCODE_W-1:0]    in_op;
    logic [CMP_W-1:0]       in_slot_ext;
    logic                   in_range;
    logic [SLOT_W-1:0]      in_slot;
    logic [CMP_W-1:0]       scan_ext;
    logic                   accept;
    logic                   load_out;

    logic                   ram_we;
    logic [SLOT_W-1:0]      ram_waddr;
    logic [COUNT_W-1:0]     ram_wdata;
    logic [COUNT_W-1:0]     ram_rdata;
    logic                   cnt_zero;
    logic [COUNT_W-1:0]     cnt_dec;

    // Counter store
    dspc_ram #(
        .WIDTH  (COUNT_W),
        .DEPTH  (NUM_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Decode the input beat
    assign in_op       = s_tuser[OPCODE_W-1:0];
    assign in_slot_ext = CMP_W'(s_tdata[COUNT_W +: SLOT_IDX_W]);
    assign in_range    = in_slot_ext < CMP_W'(NUM_SLOTS);
    assign in_slot     = in_slot_ext[SLOT_W-1:0];
    assign scan_ext    = CMP_W'(idx_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_RESP) && (!m_tvalid_reg || m_tready);

    // Shared countdown unit: zero test and decrement of the word read back
    assign cnt_zero = (ram_rdata == '0);
    assign cnt_dec  = ram_rdata - COUNT_W'(1);

    // Sequencer and slot state
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        free_next       = free_reg;
        done_next       = done_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_done_next   = res_done_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = rd_idx_reg;
        ram_wdata       = cnt_dec;

        // Retire the slot read in the previous cycle during a tick walk
        if (rd_vld_reg && !free_reg[rd_idx_reg]) begin
            if (cnt_zero) begin
                done_next[rd_idx_reg] = 1'b1;
            end else begin
                ram_we = 1'b1;
            end
        end

        // Drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    idx_next        = '0;
                    count_next      = s_tdata[COUNT_W-1:0];
                    res_status_next = STATUS_OK;
                    res_slot_next   = '0;
                    res_done_next   = 1'b0;
                    case (in_op)
                        OP_TICK:  state_next = ST_TICK;
                        OP_ALLOC: state_next = ST_ALLOC;
                        OP_RELEASE: begin
                            if (in_range) begin
                                free_next[in_slot] = 1'b1;
                                done_next[in_slot] = 1'b0;
                            end
                            state_next = ST_RESP;
                        end
                        OP_QUERY: begin
                            res_done_next = in_range && done_reg[in_slot];
                            state_next    = ST_RESP;
                        end
                        default: state_next = ST_RESP;
                    endcase
                end
            end
            ST_TICK: begin
                // Issue one slot read per cycle
                rd_vld_next = 1'b1;
                rd_idx_next = idx_reg;
                if (idx_reg == LAST_SLOT) begin
                    state_next = ST_RESP;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_ALLOC: begin
                // Scan upward for the lowest free slot
                if (free_reg[idx_reg]) begin
                    ram_we           = 1'b1;
                    ram_waddr        = idx_reg;
                    ram_wdata        = count_reg;
                    free_next[idx_reg] = 1'b0;
                    res_slot_next    = scan_ext[SLOT_IDX_W-1:0];
                    state_next       = ST_RESP;
                end else if (idx_reg == LAST_SLOT) begin
                    res_status_next = STATUS_NO_SLOT;
                    state_next      = ST_RESP;
                end else begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end
            ST_RESP: begin
                if (load_out) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = M_TDATA_W'({res_done_reg, res_slot_reg, res_status_reg});
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            free_reg     <= '1;
            done_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            free_reg     <= free_next;
            done_reg     <= done_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg        <= idx_next;
        count_reg      <= count_next;
        rd_idx_reg     <= rd_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_done_reg   <= res_done_next;
        m_data_reg     <= m_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // Busy in the cycle after taking a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken twice in a row");

    // Read-back pipeline only runs during a tick walk or its last retire
    a_rd_in_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (state_reg == ST_TICK || state_reg == ST_RESP))
        else $error("counter read-back outside a tick walk");

    // A no-slot result only when every slot is busy
    a_full_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && res_status_reg |-> free_reg == '0)
        else $error("no-slot reported with a free slot");

    // A fresh result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) || !$past(load_out))
        else $error("waiting result overwritten");
`endif

endmodule
